// ===== rtl/core/rcr_pkg.sv =====
`default_nettype none
package rcr_pkg;

   localparam int SCREEN_COLUMNS = 120;
   localparam int SCREEN_ROWS    = 40;
   localparam int MAP_COLS       = 32;
   localparam int MAP_ROWS       = 16;
   localparam int MAX_DEPTH      = 16;

   localparam int CELL_COUNT = MAP_COLS * MAP_ROWS;
   localparam int CELL_AW    = $clog2(CELL_COUNT);
   localparam int STEP_LIMIT = 10 * MAX_DEPTH;
   localparam int STEP_W     = $clog2(STEP_LIMIT + 1);

   // field of view is 512 angle steps, centered on the heading
   localparam int FOV_HALF   = 256;
   // column * 64 / 15 as a reciprocal multiply
   localparam int COL_RECIP  = 69906;
   localparam int COL_SHIFT  = 20;
   // ray accumulators hold pos*640 + dir*n; a cell is 163840 = 5 * 2^15 of that
   localparam int POS_W      = 25;
   localparam int DIR_W      = 16;
   localparam int POS_SCALE  = 640;
   localparam int ACC_SHIFT  = 15;
   localparam int CELL_RECIP = 205;
   localparam int CELL_SHIFT = 10;
   localparam int QUEUE_DEPTH = 2;

   localparam logic CMD_WRITE = 1'b1;

   localparam logic [3:0] GLYPH_BLANK  = 4'd0;
   localparam logic [3:0] GLYPH_FULL   = 4'd1;
   localparam logic [3:0] GLYPH_DARK   = 4'd2;
   localparam logic [3:0] GLYPH_MEDIUM = 4'd3;
   localparam logic [3:0] GLYPH_LIGHT  = 4'd4;
   localparam logic [3:0] GLYPH_HASH   = 4'd5;
   localparam logic [3:0] GLYPH_X      = 4'd6;
   localparam logic [3:0] GLYPH_DOT    = 4'd7;
   localparam logic [3:0] GLYPH_DASH   = 4'd8;
   localparam logic [3:0] GLYPH_CROSS  = 4'd9;

   typedef struct packed {
      logic        command;
      logic [6:0]  column;
      logic [12:0] pos_x;
      logic [11:0] pos_y;
      logic [11:0] view_angle;
      logic [8:0]  cell_index;
      logic        cell_wall;
   } req_type;

   typedef struct packed {
      logic [5:0] row;
      logic [3:0] glyph;
      logic       last;
   } rsp_type;

   typedef enum logic {
      JOB_RENDER,
      JOB_WRITE
   } job_kind_type;

   typedef struct packed {
      job_kind_type             kind;
      logic [6:0]               column;
      logic signed [POS_W-1:0]  qx0;
      logic signed [POS_W-1:0]  qy0;
      logic signed [DIR_W-1:0]  dir_x;
      logic signed [DIR_W-1:0]  dir_y;
      logic [8:0]               cell_index;
      logic                     cell_wall;
   } job_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_ADDR,
      BK_CHECK,
      BK_SHADE,
      BK_ROWS
   } back_state_type;

   function automatic logic [14:0] quarter_sine(input logic [4:0] idx);
      logic [14:0] v;
      unique case (idx)
         5'd0:    v = 15'd0;
         5'd1:    v = 15'd1606;
         5'd2:    v = 15'd3196;
         5'd3:    v = 15'd4756;
         5'd4:    v = 15'd6270;
         5'd5:    v = 15'd7723;
         5'd6:    v = 15'd9102;
         5'd7:    v = 15'd10394;
         5'd8:    v = 15'd11585;
         5'd9:    v = 15'd12665;
         5'd10:   v = 15'd13623;
         5'd11:   v = 15'd14449;
         5'd12:   v = 15'd15137;
         5'd13:   v = 15'd15679;
         5'd14:   v = 15'd16069;
         5'd15:   v = 15'd16305;
         default: v = 15'd16384;
      endcase
      return v;
   endfunction

   // Q1.14 sine, 4096 steps per turn, interpolated between table points
   function automatic logic signed [DIR_W-1:0] sine_q14(input logic [11:0] angle);
      logic [10:0] r;
      logic [4:0]  idx;
      logic [5:0]  frac;
      logic [14:0] lo;
      logic [14:0] hi;
      logic [16:0] prod;
      logic [14:0] v;
      r = {1'b0, angle[9:0]};
      if (angle[10]) begin
         r = 11'd1024 - r;
      end
      idx  = r[10:6];
      frac = r[5:0];
      lo   = quarter_sine(idx);
      hi   = (idx >= 5'd16) ? lo : quarter_sine(idx + 5'd1);
      prod = 17'(hi - lo) * 17'(frac);
      v    = lo + 15'(prod >> 6);
      return angle[11] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rcr_queue.sv =====
`default_nettype none
module rcr_queue
   import rcr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   output logic         full,
   output logic         pop_valid,
   input  wire logic    pop,
   output job_type      pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;

   assign full      = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/rcr_front.sv =====
`default_nettype none
module rcr_front
   import rcr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    clearing,
   input  wire logic    queue_full,
   output logic         push,
   output job_type      push_data
);

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_write_ff;
   logic [6:0]  s1_column_ff;
   logic [12:0] s1_pos_x_ff;
   logic [11:0] s1_pos_y_ff;
   logic [11:0] s1_angle_ff, s1_angle_in;
   logic [8:0]  s1_index_ff;
   logic        s1_wall_ff;

   logic        accept;
   logic        keep;
   logic [12:0] col_scaled;
   logic [29:0] col_prod;
   logic [24:0] qx0_u;
   logic [24:0] qy0_u;

   assign req_stall = clearing || (s1_valid_ff && queue_full);
   assign accept    = req_valid && !req_stall;
   // drop renders of columns off the screen here
   assign keep      = (req_data.command == CMD_WRITE)
                      || (req_data.column < 7'(SCREEN_COLUMNS));
   assign push      = s1_valid_ff && !queue_full;

   assign col_scaled  = {req_data.column, 6'b0};
   assign col_prod    = 30'(col_scaled) * 30'(COL_RECIP);
   assign s1_angle_in = req_data.view_angle - 12'(FOV_HALF)
                        + 12'(col_prod[29:COL_SHIFT]);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = keep;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_write_ff  <= (req_data.command == CMD_WRITE);
         s1_column_ff <= req_data.column;
         s1_pos_x_ff  <= req_data.pos_x;
         s1_pos_y_ff  <= req_data.pos_y;
         s1_angle_ff  <= s1_angle_in;
         s1_index_ff  <= req_data.cell_index;
         s1_wall_ff   <= req_data.cell_wall;
      end
   end

   assign qx0_u = 25'(s1_pos_x_ff) * 25'(POS_SCALE);
   assign qy0_u = 25'(s1_pos_y_ff) * 25'(POS_SCALE);

   always_comb begin
      push_data.kind       = s1_write_ff ? JOB_WRITE : JOB_RENDER;
      push_data.column     = s1_column_ff;
      push_data.qx0        = $signed(qx0_u);
      push_data.qy0        = $signed(qy0_u);
      push_data.dir_x      = sine_q14(s1_angle_ff);
      push_data.dir_y      = sine_q14(s1_angle_ff + 12'd1024);
      push_data.cell_index = s1_index_ff;
      push_data.cell_wall  = s1_wall_ff;
   end

endmodule
`default_nettype wire

// ===== rtl/core/rcr_back.sv =====
`default_nettype none
module rcr_back
   import rcr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    pop_valid,
   input  wire job_type pop_data,
   output logic         pop,
   output logic         clearing,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   back_state_type state_ff, state_in;

   logic                    map_ff [CELL_COUNT];
   logic                    map_rd_ff;

   logic [CELL_AW-1:0]      clr_ff, clr_in;
   logic signed [POS_W-1:0] qx_ff, qx_in;
   logic signed [POS_W-1:0] qy_ff, qy_in;
   logic signed [DIR_W-1:0] dx_ff, dx_in;
   logic signed [DIR_W-1:0] dy_ff, dy_in;
   logic [STEP_W-1:0]       n_ff, n_in;
   logic [6:0]              column_ff, column_in;
   logic [15:0]             num_ff, num_in;
   logic [15:0]             lo_ff, lo_in;
   logic [15:0]             hi_ff, hi_in;
   logic [5:0]              y_ff, y_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    mem_we;
   logic [CELL_AW-1:0]      mem_wa;
   logic                    mem_wd;
   logic                    rd_en;
   logic [CELL_AW-1:0]      rd_addr;

   logic [8:0]              tx, ty;
   logic [16:0]             cx_prod, cy_prod;
   logic [6:0]              cx, cy;
   logic                    outside;
   logic [15:0]             twice_n;
   logic                    is_ceiling, is_wall;
   logic [3:0]              wall_g, floor_g, row_g;
   logic [6:0]              k;

   // cell coordinate = floor(q / 163840), q known below 2^23 when nonnegative
   assign tx      = qx_ff[POS_W-2:ACC_SHIFT];
   assign ty      = qy_ff[POS_W-2:ACC_SHIFT];
   assign cx_prod = 17'(tx) * 17'(CELL_RECIP);
   assign cy_prod = 17'(ty) * 17'(CELL_RECIP);
   assign cx      = cx_prod[16:CELL_SHIFT];
   assign cy      = cy_prod[16:CELL_SHIFT];
   assign outside = qx_ff[POS_W-1] || qy_ff[POS_W-1]
                    || (cx >= 7'(MAP_COLS)) || (cy >= 7'(MAP_ROWS));
   assign rd_addr = CELL_AW'(16'(cy) * 16'(MAP_COLS) + 16'(cx));

   assign twice_n = 16'({n_ff, 1'b0});

   // rows above the span: (y+1)*2n <= num; span: num < (R-y+1)*2n
   assign is_ceiling = !num_ff[15] && (lo_ff <= num_ff);
   assign is_wall    = num_ff[15] || (num_ff < hi_ff);

   always_comb begin
      priority if (10'({n_ff, 2'b0}) <= 10'(STEP_LIMIT)) wall_g = GLYPH_FULL;
      else if (10'(n_ff) * 10'd3 < 10'(STEP_LIMIT))    wall_g = GLYPH_DARK;
      else if (10'({n_ff, 1'b0}) < 10'(STEP_LIMIT))     wall_g = GLYPH_MEDIUM;
      else if (10'(n_ff) < 10'(STEP_LIMIT))            wall_g = GLYPH_LIGHT;
      else                                              wall_g = GLYPH_BLANK;
   end

   assign k = 7'(SCREEN_ROWS) - 7'(y_ff);

   always_comb begin
      priority if (11'(k) * 11'd8 < 11'(SCREEN_ROWS))       floor_g = GLYPH_HASH;
      else if (11'(k) * 11'd4 < 11'(SCREEN_ROWS))          floor_g = GLYPH_X;
      else if (11'(k) * 11'd8 < 11'(3 * SCREEN_ROWS))      floor_g = GLYPH_DOT;
      else if (11'(k) * 11'd20 < 11'(9 * SCREEN_ROWS))     floor_g = GLYPH_DASH;
      else                                                  floor_g = GLYPH_BLANK;
   end

   always_comb begin
      priority if (column_ff == 7'(SCREEN_COLUMNS / 2) && y_ff == 6'(SCREEN_ROWS / 2)) begin
         row_g = GLYPH_CROSS;
      end else if (is_ceiling) begin
         row_g = GLYPH_BLANK;
      end else if (is_wall) begin
         row_g = wall_g;
      end else begin
         row_g = floor_g;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      n_in         = n_ff;
      column_in    = column_ff;
      num_in       = num_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = pop_data.cell_index[CELL_AW-1:0];
      mem_wd       = pop_data.cell_wall;
      rd_en        = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = 1'b0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CELL_AW'(CELL_COUNT - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (pop_valid) begin
               pop = 1'b1;
               if (pop_data.kind == JOB_WRITE) begin
                  mem_we = (10'(pop_data.cell_index) < 10'(CELL_COUNT));
               end else begin
                  qx_in     = pop_data.qx0 + POS_W'(pop_data.dir_x);
                  qy_in     = pop_data.qy0 + POS_W'(pop_data.dir_y);
                  dx_in     = pop_data.dir_x;
                  dy_in     = pop_data.dir_y;
                  n_in      = STEP_W'(1);
                  column_in = pop_data.column;
                  state_in  = BK_ADDR;
               end
            end
         end
         BK_ADDR: begin
            if (outside) begin
               n_in     = STEP_W'(STEP_LIMIT);
               state_in = BK_SHADE;
            end else begin
               rd_en    = 1'b1;
               state_in = BK_CHECK;
            end
         end
         BK_CHECK: begin
            if (map_rd_ff || n_ff == STEP_W'(STEP_LIMIT)) begin
               state_in = BK_SHADE;
            end else begin
               n_in     = n_ff + 1'b1;
               qx_in    = qx_ff + POS_W'(dx_ff);
               qy_in    = qy_ff + POS_W'(dy_ff);
               state_in = BK_ADDR;
            end
         end
         BK_SHADE: begin
            num_in   = 16'(n_ff) * 16'(SCREEN_ROWS) - 16'(20 * SCREEN_ROWS);
            lo_in    = twice_n;
            hi_in    = twice_n * 16'(SCREEN_ROWS + 1);
            y_in     = '0;
            state_in = BK_ROWS;
         end
         BK_ROWS: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_data_in.row   = y_ff;
               rsp_data_in.glyph = row_g;
               rsp_data_in.last  = (y_ff == 6'(SCREEN_ROWS - 1));
               y_in              = y_ff + 1'b1;
               lo_in             = lo_ff + twice_n;
               hi_in             = hi_ff - twice_n;
               if (y_ff == 6'(SCREEN_ROWS - 1)) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      n_ff        <= n_in;
      column_ff   <= column_in;
      num_ff      <= num_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_ff[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         map_rd_ff <= map_ff[rd_addr];
      end
   end

   assign clearing  = (state_ff == BK_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/raycast_column_renderer.sv =====
// Grid-map raycaster, one screen column per render transfer.
// req channel: a render item (command 0) casts one ray for the given column
// from the viewer pose and yields SCREEN_ROWS results on the rsp channel,
// rows top to bottom, last set on the final row. A write item (command 1)
// stores one map cell and yields no result. Renders of columns off the screen
// yield nothing. Items are handled strictly in order.
// Path: the front stage registers each item, and the two-entry queue holds
// it in a slot with a registered count before the back end sees it. The back end
// takes the item in its idle state, then walks 0.1-unit steps, each an address
// state and then a registered map read, up to 160 steps, then one setup state
// and one row per cycle while the receiver takes them. A write is handled in
// the idle state of the back end alone.
// The queue lets the front take new items while the back end marches.
// After reset the map is cleared by a pass over all 512 cells; req_stall is high
// through it. When rsp_stall is high the row output register holds its
// result and the row sequencer waits.
`default_nettype none
module raycast_column_renderer
   import rcr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    clearing;
   logic    queue_full;
   logic    push;
   job_type push_data;
   logic    pop_valid;
   logic    pop;
   job_type pop_data;

   rcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .clearing   (clearing),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   rcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_data  (pop_data)
   );

   rcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import rcr_pkg::*;

   localparam int  IDLE_LIMIT  = 6000;
   localparam int  DRAIN_WAIT  = 400;
   localparam int  RAND_ITEMS  = 385;
   localparam longint CELL_SPAN = 41943040;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   raycast_column_renderer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   bit      wall_map [CELL_COUNT];
   rsp_type glyph_rows_q [$];
   int      mismatches = 0;
   int      burst_left = 0;
   int      idle_cycles = 0;

   const int sine_points [17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
                                  12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};

   function automatic int sine_of(int a);
      int r;
      int idx;
      int v;
      a = a & 4095;
      r = a & 1023;
      if (a[10]) begin
         r = 1024 - r;
      end
      idx = r >> 6;
      if (idx >= 16) begin
         v = sine_points[16];
      end else begin
         v = sine_points[idx] + ((sine_points[idx + 1] - sine_points[idx]) * (r & 63)) / 64;
      end
      return a[11] ? -v : v;
   endfunction

   // -1 when the ray point lies before the map
   function automatic longint cell_of(longint pos, longint dir, longint n);
      longint p;
      p = pos * 163840 + dir * n * 256;
      if (p < 0) begin
         return -1;
      end
      return p / CELL_SPAN;
   endfunction

   function automatic longint wall_distance(req_type it, int angle);
      longint dx;
      longint dy;
      longint tx;
      longint ty;
      dx = sine_of(angle);
      dy = sine_of(angle + 1024);
      for (longint n = 1; n <= STEP_LIMIT; n++) begin
         tx = cell_of(it.pos_x, dx, n);
         ty = cell_of(it.pos_y, dy, n);
         if (tx < 0 || tx >= MAP_COLS || ty < 0 || ty >= MAP_ROWS) begin
            return STEP_LIMIT;
         end
         if (wall_map[ty * MAP_COLS + tx]) begin
            return n;
         end
      end
      return STEP_LIMIT;
   endfunction

   function automatic logic [3:0] floor_shade(int y);
      int k;
      k = SCREEN_ROWS - y;
      if (8 * k < SCREEN_ROWS) return GLYPH_HASH;
      if (4 * k < SCREEN_ROWS) return GLYPH_X;
      if (8 * k < 3 * SCREEN_ROWS) return GLYPH_DOT;
      if (20 * k < 9 * SCREEN_ROWS) return GLYPH_DASH;
      return GLYPH_BLANK;
   endfunction

   function automatic logic [3:0] wall_shade(longint n);
      if (4 * n <= STEP_LIMIT) return GLYPH_FULL;
      if (3 * n < STEP_LIMIT) return GLYPH_DARK;
      if (2 * n < STEP_LIMIT) return GLYPH_MEDIUM;
      if (n < STEP_LIMIT) return GLYPH_LIGHT;
      return GLYPH_BLANK;
   endfunction

   // update the map or queue the glyphs of one column
   function automatic void predict_column(req_type it);
      int      angle;
      longint  n;
      longint  top;
      rsp_type r;
      if (it.command == CMD_WRITE) begin
         if (it.cell_index < CELL_COUNT) begin
            wall_map[it.cell_index] = it.cell_wall;
         end
         return;
      end
      if (it.column >= SCREEN_COLUMNS) begin
         return;
      end
      angle = it.view_angle + 4096 - FOV_HALF + (it.column * 512) / SCREEN_COLUMNS;
      n = wall_distance(it, angle);
      top = (longint'(SCREEN_ROWS) * n - 20 * SCREEN_ROWS) / (2 * n);
      for (int y = 0; y < SCREEN_ROWS; y++) begin
         r.row  = 6'(y);
         r.last = (y == SCREEN_ROWS - 1);
         if (y < top) r.glyph = GLYPH_BLANK;
         else if (y <= SCREEN_ROWS - top) r.glyph = wall_shade(n);
         else r.glyph = floor_shade(y);
         if (it.column == SCREEN_COLUMNS / 2 && y == SCREEN_ROWS / 2) begin
            r.glyph = GLYPH_CROSS;
         end
         glyph_rows_q.push_back(r);
      end
   endfunction

   task automatic send_item(req_type it);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 6)) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid = 1'b1;
      req_data  = it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_column(it);
      burst_left--;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic req_type render_item(int col, int px, int py, int ang);
      req_type it;
      it = req_type'($urandom());
      it.command    = ~CMD_WRITE;
      it.column     = 7'(col);
      it.pos_x      = 13'(px);
      it.pos_y      = 12'(py);
      it.view_angle = 12'(ang);
      return it;
   endfunction

   function automatic req_type cell_item(int idx, bit wall);
      req_type it;
      it = req_type'({$urandom(), $urandom()});
      it.command    = CMD_WRITE;
      it.cell_index = 9'(idx);
      it.cell_wall  = wall;
      return it;
   endfunction

   task automatic test_open_map();
      send_item(render_item(0, 0, 0, 0));
      send_item(render_item(119, 8191, 4095, 4095));
      send_item(render_item(60, 4096, 2048, 1024));
      send_item(render_item(120, 4096, 2048, 0));
      send_item(render_item(127, 4096, 2048, 0));
      send_item(render_item(30, 16 * 256, 8 * 256, 2048));
   endtask

   task automatic test_walls();
      send_item(cell_item(0, 1'b1));
      send_item(cell_item(CELL_COUNT - 1, 1'b1));
      send_item(cell_item(8 * 32 + 17, 1'b1));
      send_item(cell_item(8 * 32 + 20, 1'b1));
      send_item(cell_item(8 * 32 + 30, 1'b1));
      // viewer at (16.5, 8.5) facing +x: walls near, mid and far
      send_item(render_item(60, 16 * 256 + 128, 8 * 256 + 128, 1024));
      send_item(render_item(0, 16 * 256 + 128, 8 * 256 + 128, 1024));
      send_item(render_item(119, 16 * 256 + 128, 8 * 256 + 128, 1024));
      send_item(cell_item(8 * 32 + 17, 1'b0));
      send_item(render_item(60, 16 * 256 + 128, 8 * 256 + 128, 1024));
      send_item(cell_item(8 * 32 + 20, 1'b0));
      send_item(render_item(60, 16 * 256 + 128, 8 * 256 + 128, 1024));
      // viewer inside a wall cell
      send_item(render_item(60, 128, 128, 0));
      send_item(cell_item(0, 1'b0));
      send_item(cell_item(CELL_COUNT - 1, 1'b0));
   endtask

   task automatic test_random();
      int sent;
      int density;
      req_type it;
      sent = 0;
      density = 15;
      while (sent < RAND_ITEMS) begin
         if ($urandom_range(0, 99) < 30) begin
            it = cell_item($urandom_range(0, CELL_COUNT - 1), $urandom_range(0, 99) < density);
         end else begin
            it = render_item($urandom_range(0, 99) < 5 ? $urandom_range(120, 127)
                                                        : $urandom_range(0, 119),
                             $urandom_range(0, 8191), $urandom_range(0, 4095),
                             $urandom_range(0, 4095));
         end
         if ($urandom_range(0, 49) == 0) begin
            density = $urandom_range(0, 60);
         end
         send_item(it);
         if (it.command == CMD_WRITE || it.column < SCREEN_COLUMNS) begin
            sent++;
         end
      end
   endtask

   // receiver stall pattern: runs of free flow, light and heavy back-pressure
   always @(negedge clock) begin
      static int mode = 0;
      static int span = 0;
      if (span == 0) begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(20, 200);
      end
      span--;
      rsp_stall <= (mode == 1) ? ($urandom_range(0, 3) == 0)
                 : (mode == 2) ? ($urandom_range(0, 9) < 8) : 1'b0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (glyph_rows_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected transfer row=%0d glyph=%0d last=%0b",
                        rsp_data.row, rsp_data.glyph, rsp_data.last);
            end
         end else begin
            want = glyph_rows_q.pop_front();
            if (rsp_data.row !== want.row || rsp_data.glyph !== want.glyph ||
                rsp_data.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected row=%0d glyph=%0d last=%0b, got row=%0d glyph=%0d last=%0b",
                           want.row, want.glyph, want.last,
                           rsp_data.row, rsp_data.glyph, rsp_data.last);
               end
            end
         end
      end
   end

   // count cycles in which no transfer happens on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > IDLE_LIMIT) begin
         $display("raycast_column_renderer regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (3) @(negedge clock);
      reset = 1'b0;
      test_open_map();
      test_walls();
      test_random();
      while (glyph_rows_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("raycast_column_renderer regression: pass");
      end else begin
         $display("raycast_column_renderer regression: fail");
      end
      $finish;
   end

endmodule
